FILE: rtl/sgtt_pkg.sv
`default_nettype none

package sgtt_pkg;

    // count limit after reset
    localparam logic [15:0] LIMIT_RESET = 16'd6000;

    // parse phase
    typedef enum logic [1:0] {
        PH_COUNT  = 2'd0,
        PH_STRIP  = 2'd1,
        PH_CORNER = 2'd2,
        PH_SKIP   = 2'd3
    } t_phase;

    // result kind codes
    typedef enum logic [1:0] {
        KIND_TRIANGLE = 2'd0,
        KIND_DONE     = 2'd1,
        KIND_RANGE    = 2'd2,
        KIND_TRUNC    = 2'd3
    } t_kind;

    typedef struct packed {
        logic [15:0] pos;
        logic [15:0] u;
        logic [15:0] v;
    } t_corner;

    typedef struct packed {
        t_kind       kind;
        t_corner     first;
        t_corner     second;
        t_corner     third;
        logic [15:0] max_position;
    } t_result;

endpackage

`default_nettype wire

FILE: rtl/sgtt_parser.sv
`default_nettype none

module sgtt_parser
    import sgtt_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_write,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        i_accept,
    input  wire logic [15:0] i_data_word,
    input  wire logic        i_buffer_end,
    output t_result          o_result,
    output logic             o_result_valid
);

    // parse state
    t_phase      r_phase, n_phase;
    logic [15:0] r_groups_left, n_groups_left;
    logic [15:0] r_corners_left, n_corners_left;
    logic        r_reversed, n_reversed;
    logic [1:0]  r_wic, n_wic;
    logic [15:0] r_build_pos, n_build_pos;
    logic [15:0] r_build_u, n_build_u;
    t_corner     r_older, n_older;
    t_corner     r_newer, n_newer;
    logic [1:0]  r_seen, n_seen;
    logic        r_parity, n_parity;
    logic [15:0] r_largest, n_largest;
    logic [15:0] r_limit;

    // working values of the current beat
    logic [15:0] mag;
    t_corner     cur_corner;
    t_corner     tri_a;
    t_corner     tri_b;
    logic        tri_ok;
    logic [15:0] corners_dec;
    logic [15:0] groups_dec;
    t_phase      end_phase;

    function automatic t_phase fail_phase(t_kind k, logic be);
        fail_phase = (k == KIND_RANGE && !be) ? PH_SKIP : PH_COUNT;
    endfunction

    // next state and result for the accepted word
    always_comb begin
        n_phase        = r_phase;
        n_groups_left  = r_groups_left;
        n_corners_left = r_corners_left;
        n_reversed     = r_reversed;
        n_wic          = r_wic;
        n_build_pos    = r_build_pos;
        n_build_u      = r_build_u;
        n_older        = r_older;
        n_newer        = r_newer;
        n_seen         = r_seen;
        n_parity       = r_parity;
        n_largest      = r_largest;
        o_result       = '0;
        o_result_valid = 1'b0;

        mag         = i_data_word[15] ? 16'(16'd0 - i_data_word) : i_data_word;
        cur_corner  = '{pos: r_build_pos, u: r_build_u, v: i_data_word};
        tri_a       = (r_parity ^ r_reversed) ? r_newer : r_older;
        tri_b       = (r_parity ^ r_reversed) ? r_older : r_newer;
        tri_ok      = (tri_a.pos != tri_b.pos) && (tri_b.pos != cur_corner.pos)
                      && (tri_a.pos != cur_corner.pos);
        corners_dec = r_corners_left - 16'd1;
        groups_dec  = r_groups_left - 16'd1;
        end_phase   = r_phase;
        if (corners_dec == 16'd0) begin
            end_phase = (groups_dec == 16'd0) ? PH_COUNT : PH_STRIP;
        end

        if (i_accept) begin
            case (r_phase)
                PH_SKIP: begin
                    if (i_buffer_end) begin
                        n_phase = PH_COUNT;
                    end
                end

                PH_COUNT: begin
                    if (i_data_word == 16'd0 || i_data_word > r_limit) begin
                        n_wic          = 2'd0;
                        n_phase        = fail_phase(KIND_RANGE, i_buffer_end);
                        o_result_valid = 1'b1;
                        o_result.kind  = KIND_RANGE;
                    end else begin
                        n_groups_left = i_data_word;
                        n_largest     = 16'd0;
                        n_phase       = PH_STRIP;
                        if (i_buffer_end) begin
                            n_wic          = 2'd0;
                            n_phase        = PH_COUNT;
                            o_result_valid = 1'b1;
                            o_result.kind  = KIND_TRUNC;
                        end
                    end
                end

                PH_STRIP: begin
                    if (mag == 16'd0 || mag > r_limit) begin
                        n_wic          = 2'd0;
                        n_phase        = fail_phase(KIND_RANGE, i_buffer_end);
                        o_result_valid = 1'b1;
                        o_result.kind  = KIND_RANGE;
                    end else begin
                        n_corners_left = mag;
                        n_reversed     = i_data_word[15];
                        n_seen         = 2'd0;
                        n_parity       = 1'b0;
                        n_wic          = 2'd0;
                        n_phase        = PH_CORNER;
                        if (i_buffer_end) begin
                            n_phase        = PH_COUNT;
                            o_result_valid = 1'b1;
                            o_result.kind  = KIND_TRUNC;
                        end
                    end
                end

                default: begin
                    case (r_wic)
                        // position word
                        2'd0: begin
                            n_build_pos = i_data_word;
                            if (i_data_word > r_largest) begin
                                n_largest = i_data_word;
                            end
                            n_wic = 2'd1;
                            if (i_buffer_end) begin
                                n_wic          = 2'd0;
                                n_phase        = PH_COUNT;
                                o_result_valid = 1'b1;
                                o_result.kind  = KIND_TRUNC;
                            end
                        end

                        // u word, done is known here on the last corner
                        2'd1: begin
                            n_build_u = i_data_word;
                            n_wic     = 2'd2;
                            if (i_buffer_end) begin
                                n_wic          = 2'd0;
                                n_phase        = PH_COUNT;
                                o_result_valid = 1'b1;
                                o_result.kind  = KIND_TRUNC;
                            end else if (r_corners_left == 16'd1
                                         && r_groups_left == 16'd1) begin
                                o_result_valid        = 1'b1;
                                o_result.kind         = KIND_DONE;
                                o_result.max_position = r_largest;
                            end
                        end

                        // v word closes the corner
                        default: begin
                            n_wic = 2'd0;
                            if (r_seen == 2'd2) begin
                                n_parity = ~r_parity;
                            end else begin
                                n_seen = r_seen + 2'd1;
                            end
                            n_older        = r_newer;
                            n_newer        = cur_corner;
                            n_corners_left = corners_dec;
                            if (corners_dec == 16'd0) begin
                                n_groups_left = groups_dec;
                            end
                            n_phase = end_phase;
                            if (i_buffer_end && end_phase != PH_COUNT) begin
                                n_phase        = PH_COUNT;
                                o_result_valid = 1'b1;
                                o_result.kind  = KIND_TRUNC;
                            end else if (r_seen == 2'd2 && tri_ok) begin
                                o_result_valid = 1'b1;
                                o_result.kind  = KIND_TRIANGLE;
                                o_result.first  = tri_a;
                                o_result.second = tri_b;
                                o_result.third  = cur_corner;
                            end
                        end
                    endcase
                end
            endcase
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_COUNT;
            r_groups_left  <= '0;
            r_corners_left <= '0;
            r_reversed     <= 1'b0;
            r_wic          <= '0;
            r_seen         <= '0;
            r_parity       <= 1'b0;
            r_largest      <= '0;
        end else begin
            r_phase        <= n_phase;
            r_groups_left  <= n_groups_left;
            r_corners_left <= n_corners_left;
            r_reversed     <= n_reversed;
            r_wic          <= n_wic;
            r_seen         <= n_seen;
            r_parity       <= n_parity;
            r_largest      <= n_largest;
        end
    end

    // corner storage
    always_ff @(posedge i_clk) begin
        r_build_pos <= n_build_pos;
        r_build_u   <= n_build_u;
        r_older     <= n_older;
        r_newer     <= n_newer;
    end

    // count limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_write) begin
            r_limit <= i_cfg_data;
        end
    end

`ifndef SYNTH
    a_wic_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wic != 2'd3)
        else $error("word-in-corner counter out of range");

    a_seen_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen != 2'd3)
        else $error("corner count out of range");

    a_skip_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_SKIP |-> r_wic == 2'd0)
        else $error("skipping with a partial corner");
`endif

endmodule

`default_nettype wire

FILE: rtl/sgtt_skid.sv
`default_nettype none

module sgtt_skid
    import sgtt_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_result i_data,
    output logic         o_space,
    output logic         o_valid,
    input  wire logic    i_ready,
    output t_result      o_data
);

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    pop;

    assign pop     = r_out_valid && i_ready;
    assign o_space = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    // valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (pop) begin
            r_out_valid  <= r_skid_valid || i_push;
            r_skid_valid <= r_skid_valid && i_push;
        end else if (i_push) begin
            r_out_valid  <= 1'b1;
            r_skid_valid <= r_out_valid;
        end
    end

    // payload: output register and skid stage
    always_ff @(posedge i_clk) begin
        if (pop) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
                if (i_push) begin
                    r_skid <= i_data;
                end
            end else if (i_push) begin
                r_out <= i_data;
            end
        end else if (i_push) begin
            if (!r_out_valid) begin
                r_out <= i_data;
            end else begin
                r_skid <= i_data;
            end
        end
    end

`ifndef SYNTH
    a_skid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid stage full while output register empty");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> !i_push)
        else $error("beat pushed into a full skid stage");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && r_skid_valid && !i_push) |=> (r_out_valid && !r_skid_valid))
        else $error("skid stage did not drain");
`endif

endmodule

`default_nettype wire

FILE: rtl/strip_group_to_triangles_unit.sv
// A result is registered (output register or skid stage) before o_out_valid offers it.
// One word per cycle unless stalled; each word passes the parser once into a result register.
// A skid stage takes one more result while the output is stalled; input stalls once both are full.
// Reset (synchronous, active low) returns the parser to expecting a group count,
// clears the output queue and sets the count limit to 6000.
`default_nettype none

module strip_group_to_triangles_unit
    import sgtt_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [15:0] i_data_word,
    input  wire logic        i_buffer_end,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [1:0]       o_result_kind,
    output logic [15:0]      o_first_position,
    output logic [15:0]      o_first_u,
    output logic [15:0]      o_first_v,
    output logic [15:0]      o_second_position,
    output logic [15:0]      o_second_u,
    output logic [15:0]      o_second_v,
    output logic [15:0]      o_third_position,
    output logic [15:0]      o_third_u,
    output logic [15:0]      o_third_v,
    output logic [15:0]      o_max_position
);

    logic    accept;
    logic    space;
    t_result res;
    logic    res_valid;
    t_result out_data;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = space;
    assign accept      = i_in_valid && space;

    // word parser
    sgtt_parser u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_write    (i_cfg_valid),
        .i_cfg_data     (i_cfg_data),
        .i_accept       (accept),
        .i_data_word    (i_data_word),
        .i_buffer_end   (i_buffer_end),
        .o_result       (res),
        .o_result_valid (res_valid)
    );

    // result register with skid stage
    sgtt_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (res),
        .o_space (space),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (out_data)
    );

    // result fields
    assign o_result_kind     = out_data.kind;
    assign o_first_position  = out_data.first.pos;
    assign o_first_u         = out_data.first.u;
    assign o_first_v         = out_data.first.v;
    assign o_second_position = out_data.second.pos;
    assign o_second_u        = out_data.second.u;
    assign o_second_v        = out_data.second.v;
    assign o_third_position  = out_data.third.pos;
    assign o_third_u         = out_data.third.u;
    assign o_third_v         = out_data.third.v;
    assign o_max_position    = out_data.max_position;

endmodule

`default_nettype wire

FILE: test/tb.sv
`timescale 1ns / 1ps

module tb;
    import sgtt_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_WORDS = 1800;
    localparam int PRINT_CAP    = 30;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [15:0] i_data_word;
    logic        i_buffer_end;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [1:0]  o_result_kind;
    logic [15:0] o_first_position;
    logic [15:0] o_first_u;
    logic [15:0] o_first_v;
    logic [15:0] o_second_position;
    logic [15:0] o_second_u;
    logic [15:0] o_second_v;
    logic [15:0] o_third_position;
    logic [15:0] o_third_u;
    logic [15:0] o_third_v;
    logic [15:0] o_max_position;

    strip_group_to_triangles_unit i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_data_word       (i_data_word),
        .i_buffer_end      (i_buffer_end),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_result_kind     (o_result_kind),
        .o_first_position  (o_first_position),
        .o_first_u         (o_first_u),
        .o_first_v         (o_first_v),
        .o_second_position (o_second_position),
        .o_second_u        (o_second_u),
        .o_second_v        (o_second_v),
        .o_third_position  (o_third_position),
        .o_third_u         (o_third_u),
        .o_third_v         (o_third_v),
        .o_max_position    (o_max_position)
    );

    // parser state as the testbench sees it
    t_phase      mdl_phase    = PH_COUNT;
    logic [15:0] mdl_limit    = LIMIT_RESET;
    logic [15:0] groups_left  = '0;
    logic [15:0] corners_left = '0;
    logic [15:0] largest_pos  = '0;
    logic        strip_rev    = 1'b0;
    logic        tri_parity   = 1'b0;
    logic [1:0]  word_idx     = '0;
    logic [1:0]  corners_seen = '0;
    t_corner     corner_build = '0;
    t_corner     older_corner = '0;
    t_corner     newer_corner = '0;

    t_result     pending_results[$];
    int          err_count   = 0;
    int          cycle_count = 0;
    int          words_sent  = 0;
    bit          in_idle     = 1'b1;
    bit          out_idle    = 1'b1;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // run length guard
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        if (err_count < PRINT_CAP)
            $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $time);
        err_count++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_mismatch(name, got, want);
    endtask

    // error exit: skip to buffer end unless this word already ends it
    function automatic bit parse_fail(input t_kind kind, input logic be, output t_result res);
        word_idx  = '0;
        mdl_phase = (kind == KIND_RANGE && !be) ? PH_SKIP : PH_COUNT;
        res       = '0;
        res.kind  = kind;
        return 1'b1;
    endfunction

    // advance the parser by one word; returns 1 when the word yields a result
    function automatic bit parse_word(input logic [15:0] w, input logic be,
                                      output t_result res);
        logic [15:0] mag;
        t_corner     a;
        t_corner     b;
        t_corner     c;
        t_corner     tmp;
        bit          emit;
        res = '0;
        case (mdl_phase)
            PH_SKIP: begin
                if (be)
                    mdl_phase = PH_COUNT;
                return 1'b0;
            end
            PH_COUNT: begin
                if (w == 16'd0 || w > mdl_limit)
                    return parse_fail(KIND_RANGE, be, res);
                groups_left = w;
                largest_pos = '0;
                mdl_phase   = PH_STRIP;
                if (be)
                    return parse_fail(KIND_TRUNC, be, res);
                return 1'b0;
            end
            PH_STRIP: begin
                mag = w[15] ? (~w + 16'd1) : w;
                if (mag == 16'd0 || mag > mdl_limit)
                    return parse_fail(KIND_RANGE, be, res);
                corners_left = mag;
                strip_rev    = w[15];
                corners_seen = '0;
                tri_parity   = 1'b0;
                word_idx     = '0;
                mdl_phase    = PH_CORNER;
                if (be)
                    return parse_fail(KIND_TRUNC, be, res);
                return 1'b0;
            end
            PH_CORNER: begin
                if (word_idx == 2'd0) begin
                    corner_build     = '0;
                    corner_build.pos = w;
                    if (w > largest_pos)
                        largest_pos = w;
                    word_idx = 2'd1;
                    if (be)
                        return parse_fail(KIND_TRUNC, be, res);
                    return 1'b0;
                end
                if (word_idx == 2'd1) begin
                    corner_build.u = w;
                    word_idx       = 2'd2;
                    if (be)
                        return parse_fail(KIND_TRUNC, be, res);
                    // the parse can no longer fail once the last corner's u word is in
                    if (corners_left == 16'd1 && groups_left == 16'd1) begin
                        res.kind         = KIND_DONE;
                        res.max_position = largest_pos;
                        return 1'b1;
                    end
                    return 1'b0;
                end
                c        = corner_build;
                c.v      = w;
                word_idx = '0;
                emit     = 1'b0;
                a        = '0;
                b        = '0;
                if (corners_seen >= 2'd2) begin
                    a = older_corner;
                    b = newer_corner;
                    // odd triangles and reversed strips flip the winding
                    if (tri_parity ^ strip_rev) begin
                        tmp = a;
                        a   = b;
                        b   = tmp;
                    end
                    emit = (a.pos != b.pos) && (b.pos != c.pos) && (a.pos != c.pos);
                    tri_parity ^= 1'b1;
                end else begin
                    corners_seen++;
                end
                older_corner = newer_corner;
                newer_corner = c;
                corners_left--;
                if (corners_left == 16'd0) begin
                    groups_left--;
                    mdl_phase = (groups_left == 16'd0) ? PH_COUNT : PH_STRIP;
                end
                if (be && mdl_phase != PH_COUNT)
                    return parse_fail(KIND_TRUNC, be, res);
                if (emit) begin
                    res.kind   = KIND_TRIANGLE;
                    res.first  = a;
                    res.second = b;
                    res.third  = c;
                    return 1'b1;
                end
                return 1'b0;
            end
            default: begin
                mdl_phase = PH_COUNT;
                return 1'b0;
            end
        endcase
    endfunction

    // score each result beat against the oldest pending one, then model the beats in
    always @(posedge i_clk) begin
        t_result want;
        t_result fresh;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("result beat with none pending, kind",
                                    16'(o_result_kind), 16'h0000);
                end else begin
                    want = pending_results.pop_front();
                    check_field("result_kind", 16'(o_result_kind), 16'(want.kind));
                    check_field("first_position", o_first_position, want.first.pos);
                    check_field("first_u", o_first_u, want.first.u);
                    check_field("first_v", o_first_v, want.first.v);
                    check_field("second_position", o_second_position, want.second.pos);
                    check_field("second_u", o_second_u, want.second.u);
                    check_field("second_v", o_second_v, want.second.v);
                    check_field("third_position", o_third_position, want.third.pos);
                    check_field("third_u", o_third_u, want.third.u);
                    check_field("third_v", o_third_v, want.third.v);
                    check_field("max_position", o_max_position, want.max_position);
                end
            end
            if (i_cfg_valid && o_cfg_ready)
                mdl_limit = i_cfg_data;
            if (i_in_valid && o_in_ready) begin
                if (parse_word(i_data_word, i_buffer_end, fresh))
                    pending_results.insert(pending_results.size(), fresh);
            end
        end
    end

    // result side: random stall before each result beat while out_idle is set
    initial begin
        int stall;
        i_out_ready = 1'b0;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            stall = out_idle ? $urandom_range(0, 15) : 0;
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            @(negedge i_clk);
        end
    end

    // one word beat, entered and left at a falling edge
    task automatic send_word(input logic [15:0] word, input logic be);
        int gap;
        gap = in_idle ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_data_word  <= word;
        i_buffer_end <= be;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
        words_sent++;
    endtask

    task automatic send_corner(input logic [15:0] pos, input logic [15:0] u,
                               input logic [15:0] v, input logic be);
        send_word(pos, 1'b0);
        send_word(u, 1'b0);
        send_word(v, be);
    endtask

    // change the count limit only once the block has gone quiet
    task automatic write_limit(input logic [15:0] value);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] pick_count(input logic [15:0] lim, input int cap);
        int hi;
        hi = (lim < cap) ? lim : cap;
        if (hi < 1)
            hi = 1;
        if ($urandom_range(0, 15) == 0)
            return (lim == 16'd0) ? 16'd1 : lim;
        return 16'($urandom_range(1, hi));
    endfunction

    // mostly well formed parses, some with bad counts, early buffer end or noise
    task automatic send_parse();
        logic [15:0] words[$];
        logic [15:0] lim;
        logic [15:0] cnt;
        logic [15:0] mag;
        logic [15:0] pos;
        int          flavor;
        int          groups;
        int          corners;
        int          cut;
        int          last;
        bit          end_be;
        bit          forced;
        lim    = mdl_limit;
        flavor = $urandom_range(0, 19);
        cut    = -1;
        forced = 1'b0;
        if (flavor == 0) begin
            // noise words
            repeat ($urandom_range(1, 4)) words.insert(words.size(), 16'($urandom));
            end_be = 1'b1;
        end else if (flavor == 1) begin
            // group count out of range, then words to skip
            words.insert(words.size(),
                         (lim < 16'hFFFF && $urandom_range(0, 1)) ? lim + 16'd1 : 16'd0);
            repeat ($urandom_range(0, 4)) words.insert(words.size(), 16'($urandom));
            end_be = 1'b1;
        end else begin
            cnt = pick_count(lim, 3);
            words.insert(words.size(), cnt);
            groups = (cnt > 16'd3) ? 3 : int'(cnt);
            forced = (cnt > 16'd3);
            end_be = 1'b0;
            for (int g = 0; g < groups; g++) begin
                if (flavor == 2 && g == groups - 1) begin
                    // strip count out of range
                    cnt = (lim < 16'd32767 && $urandom_range(0, 1)) ? lim + 16'd1 : 16'd0;
                    if (lim < 16'h8000 && $urandom_range(0, 3) == 0)
                        cnt = 16'h8000;
                    else if ($urandom_range(0, 1))
                        cnt = ~cnt + 16'd1;
                    words.insert(words.size(), cnt);
                    repeat ($urandom_range(0, 4)) words.insert(words.size(), 16'($urandom));
                    end_be = 1'b1;
                    break;
                end
                cnt = pick_count(lim, 6);
                if ($urandom_range(0, 1))
                    cnt = ~cnt + 16'd1;
                if (lim >= 16'h8000 && $urandom_range(0, 7) == 0)
                    cnt = 16'h8000;
                mag     = cnt[15] ? (~cnt + 16'd1) : cnt;
                corners = (mag > 16'd8) ? 8 : int'(mag);
                if (mag > 16'd8)
                    forced = 1'b1;
                words.insert(words.size(), cnt);
                repeat (corners) begin
                    pos = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                       : 16'($urandom_range(0, 7));
                    words.insert(words.size(), pos);
                    words.insert(words.size(), 16'($urandom));
                    words.insert(words.size(), 16'($urandom));
                end
            end
            if (flavor != 2)
                end_be = forced ? 1'b1 : 1'($urandom_range(0, 1));
            if (flavor == 3)
                cut = $urandom_range(0, words.size() - 1);
        end
        last = (cut >= 0) ? cut : words.size() - 1;
        for (int i = 0; i <= last; i++)
            send_word(words[i], (i == last) ? (cut >= 0 || end_be) : 1'b0);
    endtask

    // two groups, reversed single corner strip, then a strip with a dropped triangle
    task automatic test_strip_winding();
        write_limit(LIMIT_RESET);
        send_word(16'd2, 1'b0);
        send_word(16'hFFFF, 1'b0);
        send_corner(16'hFFFF, 16'h0000, 16'hFFFF, 1'b0);
        send_word(16'd4, 1'b0);
        send_corner(16'd0, 16'h1234, 16'h8000, 1'b0);
        send_corner(16'd5, 16'h7FFF, 16'h0001, 1'b0);
        send_corner(16'd9, 16'hA5A5, 16'h5A5A, 1'b0);
        // repeated position, done lands on its u word, buffer end on the closing word
        send_corner(16'd5, 16'hFFFE, 16'h0002, 1'b1);
    endtask

    // bad group count with skipped words, most negative strip count with buffer end
    task automatic test_count_errors();
        send_word(16'd0, 1'b0);
        send_word(16'h00FF, 1'b0);
        send_word(16'hFFFF, 1'b1);
        send_word(16'd1, 1'b0);
        send_word(16'h8000, 1'b1);
    endtask

    // buffer end on the group count, then a zero limit
    task automatic test_early_end();
        send_word(16'd3, 1'b1);
        write_limit(16'd0);
        send_word(16'd1, 1'b1);
    endtask

    task automatic test_random_streams();
        logic [15:0] limits[6];
        int          phase_end;
        limits = '{16'hFFFF, 16'd1, 16'd3, 16'($urandom_range(1, 65535)), 16'd2, LIMIT_RESET};
        foreach (limits[p]) begin
            write_limit(limits[p]);
            in_idle   = (p != 1 && p != 4);
            out_idle  = (p != 1 && p != 2);
            phase_end = words_sent + RANDOM_WORDS / 6;
            while (words_sent < phase_end)
                send_parse();
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_data   = '0;
        i_in_valid   = 1'b0;
        i_data_word  = '0;
        i_buffer_end = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_strip_winding();
        test_count_errors();
        test_early_end();
        test_random_streams();

        // drain
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        if (err_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/sgtt_pkg.sv
rtl/sgtt_parser.sv
rtl/sgtt_skid.sv
rtl/strip_group_to_triangles_unit.sv
test/tb.sv
